[rtl/core/quadratic_root_solver_assert.svh]
// Assertion macros used by the quadratic root solver queue.
// Uses the clk_i and rst_ni names of the module that includes it.
`ifndef QUADRATIC_ROOT_SOLVER_ASSERT_SVH
`define QUADRATIC_ROOT_SOLVER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define QRS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define QRS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/qrs_pkg.sv]
// Package of the quadratic root solver: widths, codes, job types and the
// saturation function. Used by every module of the block.
`default_nettype none
package qrs_pkg;
  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int GUARD_BITS = FRAC_BITS;
  localparam int PROD_W     = 2 * DATA_WIDTH;
  localparam int DISC_W     = PROD_W + 2;
  localparam int SQ_STEPS   = (DISC_W + 2 * GUARD_BITS + 1) / 2;
  localparam int ROOT_W     = SQ_STEPS;
  localparam int REM_W      = ROOT_W + 1;
  localparam int X_W        = ((ROOT_W > DATA_WIDTH + FRAC_BITS) ? ROOT_W
                                : DATA_WIDTH + FRAC_BITS) + 2;
  localparam int Y_W        = DATA_WIDTH + 1;
  localparam int DIV_STEPS  = DATA_WIDTH;
  localparam int QDEPTH     = 2;
  localparam int IN_W       = 3 * DATA_WIDTH;
  localparam int IN_TDATA_W = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W      = 4 * DATA_WIDTH + 2;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;
  localparam int OUT_TUSER_W = 3;

  localparam logic [1:0] ST_REAL    = 2'd0;
  localparam logic [1:0] ST_COMPLEX = 2'd1;
  localparam logic [1:0] ST_NO_REAL = 2'd2;
  localparam logic [1:0] ST_DEGEN   = 2'd3;

  typedef enum logic [2:0] {
    KIND_REAL, KIND_CPLX, KIND_NOREAL, KIND_DEGEN, KIND_LIN
  } kind_e;

  typedef logic [DATA_WIDTH-1:0] mag_t;

  typedef struct packed {
    kind_e             kind;
    mag_t              a_mag;
    logic              a_neg;
    mag_t              b_mag;
    logic              b_neg;
    mag_t              c_mag;
    logic              c_neg;
    logic [DISC_W-1:0] disc;
  } job_t;

  typedef struct packed {
    mag_t       first_real;
    mag_t       first_imag;
    mag_t       second_real;
    mag_t       second_imag;
    logic [1:0] root_count;
    logic [1:0] status;
    logic       saturated;
  } res_t;

  // Clips a quotient magnitude to the signed range and applies the sign.
  // The top bit of the result is the clip flag.
  function automatic logic [DATA_WIDTH:0] sat_apply(mag_t q, logic ovf, logic neg);
    mag_t lim;
    mag_t mag;
    logic clip;
    lim  = neg ? {1'b1, {(DATA_WIDTH-1){1'b0}}} : {1'b0, {(DATA_WIDTH-1){1'b1}}};
    clip = ovf || (q > lim);
    mag  = clip ? lim : q;
    return {clip, (neg ? (~mag + 1'b1) : mag)};
  endfunction
endpackage
`default_nettype wire

[rtl/core/qrs_front.sv]
// Front end: takes coefficient requests, squares and multiplies them, forms
// the discriminant and classifies the equation. Depends on qrs_pkg.
`default_nettype none
module qrs_front import qrs_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire mag_t coef_quad_i,
  input  wire mag_t coef_lin_i,
  input  wire mag_t coef_const_i,
  input  wire logic allow_complex_i,
  output logic      job_valid_o,
  input  wire logic job_ready_i,
  output job_t      job_o
);
  logic v1_q, v2_q;
  logic s2_free, s1_free;
  mag_t a_mag_q, b_mag_q, c_mag_q;
  logic a_neg_q, b_neg_q, c_neg_q;
  logic [PROD_W-1:0] bb_q, ac_q;
  mag_t a_mag_d, b_mag_d, c_mag_d;
  logic [DISC_W-1:0] bb_x, ac4, disc_d;
  logic dneg_d;
  job_t job_d, job_q;

  assign s2_free    = !v2_q || job_ready_i;
  assign s1_free    = !v1_q || s2_free;
  assign in_ready_o = s1_free;

  assign a_mag_d = coef_quad_i[DATA_WIDTH-1] ? (~coef_quad_i + 1'b1) : coef_quad_i;
  assign b_mag_d = coef_lin_i[DATA_WIDTH-1] ? (~coef_lin_i + 1'b1) : coef_lin_i;
  assign c_mag_d = coef_const_i[DATA_WIDTH-1] ? (~coef_const_i + 1'b1) : coef_const_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (s1_free) v1_q <= in_valid_i;
      if (s2_free) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_free && in_valid_i) begin
      a_mag_q <= a_mag_d;
      b_mag_q <= b_mag_d;
      c_mag_q <= c_mag_d;
      a_neg_q <= coef_quad_i[DATA_WIDTH-1];
      b_neg_q <= coef_lin_i[DATA_WIDTH-1];
      c_neg_q <= coef_const_i[DATA_WIDTH-1];
      bb_q    <= b_mag_d * b_mag_d;
      ac_q    <= a_mag_d * c_mag_d;
    end
  end

  assign bb_x = DISC_W'(bb_q);
  assign ac4  = {ac_q, 2'b00};

  always_comb begin
    dneg_d = 1'b0;
    if (a_neg_q != c_neg_q) begin
      disc_d = bb_x + ac4;
    end else if (bb_x >= ac4) begin
      disc_d = bb_x - ac4;
    end else begin
      disc_d = ac4 - bb_x;
      dneg_d = 1'b1;
    end
    job_d.a_mag = a_mag_q;
    job_d.a_neg = a_neg_q;
    job_d.b_mag = b_mag_q;
    job_d.b_neg = b_neg_q;
    job_d.c_mag = c_mag_q;
    job_d.c_neg = c_neg_q;
    job_d.disc  = disc_d;
    priority if (a_mag_q == '0 && b_mag_q == '0) begin
      job_d.kind = KIND_DEGEN;
    end else if (a_mag_q == '0) begin
      job_d.kind = KIND_LIN;
    end else if (!dneg_d) begin
      job_d.kind = KIND_REAL;
    end else if (allow_complex_i) begin
      job_d.kind = KIND_CPLX;
    end else begin
      job_d.kind = KIND_NOREAL;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_free && v1_q) job_q <= job_d;
  end

  assign job_valid_o = v2_q;
  assign job_o       = job_q;
endmodule
`default_nettype wire

[rtl/core/qrs_queue.sv]
// Short queue of classified jobs between the front end and the back end.
// Depends on qrs_pkg and the assertion macro header.
`default_nettype none
`include "quadratic_root_solver_assert.svh"
module qrs_queue import qrs_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_valid_i,
  output logic      push_ready_o,
  input  wire job_t push_job_i,
  output logic      pop_valid_o,
  input  wire logic pop_ready_i,
  output job_t      pop_job_o
);
  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  job_t entry_q [QDEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;
  logic push, pop;

  assign push_ready_o = (cnt_q != CNT_W'(QDEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_job_o    = entry_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= (wr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
      if (pop)  rd_q <= (rd_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
      if (push && !pop) cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) entry_q[wr_q] <= push_job_i;
  end

  `QRS_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(QDEPTH), "queue count out of range")
  `QRS_ASSERT_NXT(a_cnt_dec, pop && !push, cnt_q == $past(cnt_q) - 1'b1, "queue pop lost")
  `QRS_ASSERT_NXT(a_cnt_inc, push && !pop, cnt_q == $past(cnt_q) + 1'b1, "queue push lost")
endmodule
`default_nettype wire

[rtl/core/qrs_back.sv]
// Back end: pipelined square root, two pipelined rounding dividers and the
// saturating result register. Depends on qrs_pkg.
`default_nettype none
module qrs_back import qrs_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic job_valid_i,
  output logic      job_ready_o,
  input  wire job_t job_i,
  output logic      res_valid_o,
  input  wire logic res_ready_i,
  output res_t      res_o
);
  localparam int SW = X_W + 1;

  typedef struct packed {
    kind_e             kind;
    mag_t              a_mag;
    logic              a_neg;
    mag_t              b_mag;
    logic              b_neg;
    mag_t              c_mag;
    logic              c_neg;
    logic [ROOT_W-1:0] root;
    logic [REM_W-1:0]  rem;
    logic [DISC_W-1:0] dsh;
  } sq_t;

  typedef struct packed {
    kind_e          kind;
    logic           n1;
    logic           n2;
    logic           ni;
    logic [Y_W-1:0] y;
    logic [Y_W-1:0] r1;
    logic [Y_W-1:0] r2;
    mag_t           q1;
    mag_t           q2;
    logic           ov1;
    logic           ov2;
    mag_t           x1;
    mag_t           x2;
  } dv_t;

  function automatic sq_t sq_step(sq_t s);
    sq_t o;
    logic [REM_W+1:0] cur, trial;
    o     = s;
    cur   = {s.rem, s.dsh[DISC_W-1 -: 2]};
    trial = (REM_W+2)'({s.root, 2'b01});
    o.dsh = s.dsh << 2;
    if (cur >= trial) begin
      o.rem  = REM_W'(cur - trial);
      o.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      o.rem  = REM_W'(cur);
      o.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return o;
  endfunction

  function automatic logic [Y_W:0] div_step(logic [Y_W-1:0] r, logic b,
                                            logic [Y_W-1:0] y);
    logic [Y_W:0] cur;
    logic [Y_W:0] dif;
    cur = {r, b};
    dif = cur - {1'b0, y};
    if (cur >= {1'b0, y}) return {1'b1, dif[Y_W-1:0]};
    return {1'b0, cur[Y_W-1:0]};
  endfunction

  logic en;
  logic sqv_q [SQ_STEPS+1];
  sq_t  sq_q  [SQ_STEPS+1];
  logic dvv_q [DIV_STEPS+1];
  dv_t  dv_q  [DIV_STEPS+1];
  logic out_valid_q;
  res_t out_q;
  sq_t  sq_init;
  dv_t  dv_init;
  res_t res_d;

  assign en          = !out_valid_q || res_ready_i;
  assign job_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= SQ_STEPS; i++) sqv_q[i] <= 1'b0;
      for (int i = 0; i <= DIV_STEPS; i++) dvv_q[i] <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      sqv_q[0] <= job_valid_i;
      for (int i = 1; i <= SQ_STEPS; i++) sqv_q[i] <= sqv_q[i-1];
      dvv_q[0] <= sqv_q[SQ_STEPS];
      for (int i = 1; i <= DIV_STEPS; i++) dvv_q[i] <= dvv_q[i-1];
      out_valid_q <= dvv_q[DIV_STEPS];
    end
  end

  always_comb begin
    sq_init.kind  = job_i.kind;
    sq_init.a_mag = job_i.a_mag;
    sq_init.a_neg = job_i.a_neg;
    sq_init.b_mag = job_i.b_mag;
    sq_init.b_neg = job_i.b_neg;
    sq_init.c_mag = job_i.c_mag;
    sq_init.c_neg = job_i.c_neg;
    sq_init.root  = '0;
    sq_init.rem   = '0;
    sq_init.dsh   = job_i.disc;
  end

  always_ff @(posedge clk_i) begin
    if (en) sq_q[0] <= sq_init;
  end

  for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sqrt
    always_ff @(posedge clk_i) begin
      if (en) sq_q[g+1] <= sq_step(sq_q[g]);
    end
  end

  always_comb begin
    sq_t s;
    logic [SW-1:0] nb_u, nbv, sv, n1s, n2s, a1, a2;
    logic [X_W-1:0] x1, x2, am;
    s    = sq_q[SQ_STEPS];
    am   = X_W'(s.a_mag);
    nb_u = SW'(s.b_mag) << GUARD_BITS;
    nbv  = s.b_neg ? nb_u : (~nb_u + 1'b1);
    sv   = SW'(s.root);
    n1s  = nbv - sv;
    n2s  = nbv + sv;
    a1   = n1s[SW-1] ? (~n1s + 1'b1) : n1s;
    a2   = n2s[SW-1] ? (~n2s + 1'b1) : n2s;
    dv_init.kind = s.kind;
    dv_init.y    = {s.a_mag, 1'b0};
    dv_init.ni   = !s.a_neg;
    x1 = X_W'(a1) + am;
    x2 = X_W'(a2) + am;
    dv_init.n1 = n1s[SW-1] ^ s.a_neg;
    dv_init.n2 = n2s[SW-1] ^ s.a_neg;
    unique case (s.kind)
      KIND_CPLX: begin
        a1 = nbv[SW-1] ? (~nbv + 1'b1) : nbv;
        x1 = X_W'(a1) + am;
        x2 = X_W'(s.root) + am;
        dv_init.n1 = nbv[SW-1] ^ s.a_neg;
      end
      KIND_LIN: begin
        x1 = (X_W'(s.c_mag) << (FRAC_BITS + 1)) + X_W'(s.b_mag);
        dv_init.y  = {s.b_mag, 1'b0};
        dv_init.n1 = !s.c_neg ^ s.b_neg;
      end
      KIND_REAL, KIND_NOREAL, KIND_DEGEN: begin
      end
      default: begin
      end
    endcase
    dv_init.r1  = Y_W'(x1[X_W-1:DIV_STEPS]);
    dv_init.r2  = Y_W'(x2[X_W-1:DIV_STEPS]);
    dv_init.ov1 = Y_W'(x1[X_W-1:DIV_STEPS]) >= dv_init.y;
    dv_init.ov2 = Y_W'(x2[X_W-1:DIV_STEPS]) >= dv_init.y;
    dv_init.x1  = x1[DIV_STEPS-1:0];
    dv_init.x2  = x2[DIV_STEPS-1:0];
    dv_init.q1  = '0;
    dv_init.q2  = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en) dv_q[0] <= dv_init;
  end

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
    dv_t nxt;
    logic [Y_W:0] st1, st2;
    always_comb begin
      st1    = div_step(dv_q[g].r1, dv_q[g].x1[DATA_WIDTH-1], dv_q[g].y);
      st2    = div_step(dv_q[g].r2, dv_q[g].x2[DATA_WIDTH-1], dv_q[g].y);
      nxt    = dv_q[g];
      nxt.r1 = st1[Y_W-1:0];
      nxt.r2 = st2[Y_W-1:0];
      nxt.q1 = {dv_q[g].q1[DATA_WIDTH-2:0], st1[Y_W]};
      nxt.q2 = {dv_q[g].q2[DATA_WIDTH-2:0], st2[Y_W]};
      nxt.x1 = dv_q[g].x1 << 1;
      nxt.x2 = dv_q[g].x2 << 1;
    end
    always_ff @(posedge clk_i) begin
      if (en) dv_q[g+1] <= nxt;
    end
  end

  always_comb begin
    dv_t d;
    logic [DATA_WIDTH:0] s1, s2, si1, si2;
    d   = dv_q[DIV_STEPS];
    s1  = sat_apply(d.q1, d.ov1, d.n1);
    s2  = sat_apply(d.q2, d.ov2, d.n2);
    si1 = sat_apply(d.q2, d.ov2, d.ni);
    si2 = sat_apply(d.q2, d.ov2, !d.ni);
    res_d = '0;
    unique case (d.kind)
      KIND_REAL: begin
        res_d.first_real  = s1[DATA_WIDTH-1:0];
        res_d.second_real = s2[DATA_WIDTH-1:0];
        res_d.root_count  = 2'd2;
        res_d.status      = ST_REAL;
        res_d.saturated   = s1[DATA_WIDTH] | s2[DATA_WIDTH];
      end
      KIND_CPLX: begin
        res_d.first_real  = s1[DATA_WIDTH-1:0];
        res_d.second_real = s1[DATA_WIDTH-1:0];
        res_d.first_imag  = si1[DATA_WIDTH-1:0];
        res_d.second_imag = si2[DATA_WIDTH-1:0];
        res_d.root_count  = 2'd2;
        res_d.status      = ST_COMPLEX;
        res_d.saturated   = s1[DATA_WIDTH] | si1[DATA_WIDTH] | si2[DATA_WIDTH];
      end
      KIND_LIN: begin
        res_d.first_real = s1[DATA_WIDTH-1:0];
        res_d.root_count = 2'd1;
        res_d.status     = ST_REAL;
        res_d.saturated  = s1[DATA_WIDTH];
      end
      KIND_NOREAL: res_d.status = ST_NO_REAL;
      KIND_DEGEN:  res_d.status = ST_DEGEN;
      default:     res_d.status = ST_DEGEN;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) out_q <= res_d;
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;
endmodule
`default_nettype wire

[rtl/core/quadratic_root_solver.sv]
// Top level of the quadratic root solver: front end, job queue, back end
// and the option register. Depends on qrs_pkg, qrs_front, qrs_queue, qrs_back.
//
//   channel   direction  payload
//   s_axis    in         coef_quad, coef_lin, coef_const
//   m_axis    out        roots and root_count in tdata, status and saturated in tuser
//   cfg       in         allow_complex
//
// One request is accepted per clock while the output side keeps up.
// The square root and divider pipelines resolve one bit per stage.
// Reset empties every stage and sets allow_complex to 1.
// The front end stalls only when the queue is full; the back end stalls as a
// whole while its result register is held.
`default_nettype none
module quadratic_root_solver import qrs_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // coef_quad, coef_lin, coef_const
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // first_real, first_imag, second_real, second_imag, root_count, zero fill
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
  // status, saturated
  output logic [OUT_TUSER_W-1:0]      m_axis_tuser,
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic                   cfg_data_i
);
  logic allow_complex_q;
  logic f_valid, f_ready, b_valid, b_ready;
  job_t f_job, b_job;
  res_t res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) allow_complex_q <= 1'b1;
    else if (cfg_valid_i) allow_complex_q <= cfg_data_i;
  end

  qrs_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (s_axis_tvalid),
    .in_ready_o      (s_axis_tready),
    .coef_quad_i     (s_axis_tdata[DATA_WIDTH-1:0]),
    .coef_lin_i      (s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
    .coef_const_i    (s_axis_tdata[3*DATA_WIDTH-1:2*DATA_WIDTH]),
    .allow_complex_i (allow_complex_q),
    .job_valid_o     (f_valid),
    .job_ready_i     (f_ready),
    .job_o           (f_job)
  );

  qrs_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_job_i   (f_job),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_job_o    (b_job)
  );

  qrs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (b_valid),
    .job_ready_o (b_ready),
    .job_i       (b_job),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = OUT_TDATA_W'({res.root_count,
                                      res.second_imag, res.second_real,
                                      res.first_imag, res.first_real});
  assign m_axis_tuser = {res.saturated, res.status};
endmodule
`default_nettype wire

[sim/quadratic_root_solver_checker.sv]
// Checker for the quadratic root solver: watches the coefficient, root and
// option channels, predicts every result and compares it field by field.
// Depends on qrs_pkg for the widths and status codes.
module quadratic_root_solver_checker import qrs_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic [OUT_TUSER_W-1:0] m_axis_tuser,
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_o,
  input  logic                   cfg_data_i,
  output int                     fail_count_o,
  output int                     pending_o,
  output int                     roots_seen_o
);
  typedef logic signed [127:0] wide_t;

  res_t roots_expected[$];
  logic complex_on;

  function automatic logic [63:0] isqrt_floor(wide_t x);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int i = 50; i >= 0; i--) begin
      t = r | (64'd1 << i);
      if (wide_t'(t) * wide_t'(t) <= x) r = t;
    end
    return r;
  endfunction

  // Rounded, saturated num * 2^FRAC_BITS / den, ties away from zero.
  function automatic mag_t scale_round(wide_t num, wide_t den, inout logic sat);
    wide_t nm, dm, q, lim;
    logic neg;
    neg = (num < 0) != (den < 0);
    nm  = (num < 0) ? -num : num;
    dm  = (den < 0) ? -den : den;
    q   = ((nm << (FRAC_BITS + 1)) + dm) / (dm << 1);
    lim = neg ? (wide_t'(1) <<< (DATA_WIDTH - 1)) : ((wide_t'(1) <<< (DATA_WIDTH - 1)) - 1);
    if (q > lim) begin
      q = lim;
      sat = 1'b1;
    end
    if (q == 0) neg = 1'b0;
    return neg ? mag_t'(-q) : mag_t'(q);
  endfunction

  function automatic res_t predict_roots(mag_t ra, mag_t rb, mag_t rc, logic cplx);
    res_t r;
    wide_t a, b, c, disc, s, den, nb;
    logic sat;
    r = '0;
    sat = 1'b0;
    a = wide_t'($signed(ra));
    b = wide_t'($signed(rb));
    c = wide_t'($signed(rc));
    if (a == 0) begin
      if (b == 0) begin
        r.status = ST_DEGEN;
      end else begin
        r.first_real = scale_round(-c, b, sat);
        r.root_count = 2'd1;
        r.status = ST_REAL;
      end
    end else begin
      disc = b * b - 4 * a * c;
      den  = a <<< (GUARD_BITS + 1);
      nb   = -(b <<< GUARD_BITS);
      if (disc >= 0) begin
        s = wide_t'(isqrt_floor(disc <<< (2 * GUARD_BITS)));
        r.first_real  = scale_round(nb - s, den, sat);
        r.second_real = scale_round(nb + s, den, sat);
        r.root_count = 2'd2;
        r.status = ST_REAL;
      end else if (cplx) begin
        s = wide_t'(isqrt_floor((-disc) <<< (2 * GUARD_BITS)));
        r.first_real  = scale_round(nb, den, sat);
        r.first_imag  = scale_round(-s, den, sat);
        r.second_real = r.first_real;
        r.second_imag = scale_round(s, den, sat);
        r.root_count = 2'd2;
        r.status = ST_COMPLEX;
      end else begin
        r.status = ST_NO_REAL;
      end
    end
    r.saturated = sat;
    return r;
  endfunction

  initial begin
    fail_count_o = 0;
    roots_seen_o = 0;
    complex_on = 1'b1;
  end

  assign pending_o = roots_expected.size();

  always @(posedge clk_i) begin
    res_t got, exp_r;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) complex_on <= cfg_data_i;
      if (s_axis_tvalid && s_axis_tready)
        roots_expected.push_back(predict_roots(s_axis_tdata[31:0], s_axis_tdata[63:32],
                                               s_axis_tdata[95:64], complex_on));
      if (m_axis_tvalid && m_axis_tready) begin
        got.first_real  = m_axis_tdata[31:0];
        got.first_imag  = m_axis_tdata[63:32];
        got.second_real = m_axis_tdata[95:64];
        got.second_imag = m_axis_tdata[127:96];
        got.root_count  = m_axis_tdata[129:128];
        got.status      = m_axis_tuser[1:0];
        got.saturated   = m_axis_tuser[2];
        roots_seen_o++;
        if (roots_expected.size() == 0) begin
          $error("Result arrived with no request pending.");
          fail_count_o++;
        end else begin
          exp_r = roots_expected.pop_front();
          if (got.first_real !== exp_r.first_real) begin
            $error("first_real: expected %0d, got %0d", $signed(exp_r.first_real),
                   $signed(got.first_real));
            fail_count_o++;
          end
          if (got.first_imag !== exp_r.first_imag) begin
            $error("first_imag: expected %0d, got %0d", $signed(exp_r.first_imag),
                   $signed(got.first_imag));
            fail_count_o++;
          end
          if (got.second_real !== exp_r.second_real) begin
            $error("second_real: expected %0d, got %0d", $signed(exp_r.second_real),
                   $signed(got.second_real));
            fail_count_o++;
          end
          if (got.second_imag !== exp_r.second_imag) begin
            $error("second_imag: expected %0d, got %0d", $signed(exp_r.second_imag),
                   $signed(got.second_imag));
            fail_count_o++;
          end
          if (got.root_count !== exp_r.root_count) begin
            $error("root_count: expected %0d, got %0d", exp_r.root_count, got.root_count);
            fail_count_o++;
          end
          if (got.status !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, got.status);
            fail_count_o++;
          end
          if (got.saturated !== exp_r.saturated) begin
            $error("saturated: expected %0d, got %0d", exp_r.saturated, got.saturated);
            fail_count_o++;
          end
        end
      end
    end
  end
endmodule

[sim/tb_quadratic_root_solver.sv]
// Testbench top for the quadratic root solver: clock, reset, coefficient
// stimulus, output back-pressure, option writes and the verdict.
// Depends on qrs_pkg, quadratic_root_solver and quadratic_root_solver_checker.
module tb_quadratic_root_solver;
  import qrs_pkg::*;

  localparam int Latency = SQ_STEPS + DIV_STEPS + 5;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [OUT_TUSER_W-1:0] m_axis_tuser;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic                   cfg_data_i;
  int                     fail_count;
  int                     pending;
  int                     roots_seen;
  int                     requests_sent;
  int                     burst_left;
  int                     hold_cycles;

  quadratic_root_solver i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  quadratic_root_solver_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .roots_seen_o  (roots_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #(12 * 2_000_000);
    $display("tb_quadratic_root_solver failed");
    $finish;
  end

  // The receiver changes its stall pattern after a randomly drawn interval and
  // holds off completely whenever a long stall is requested.
  initial begin
    int mode;
    int mode_left;
    m_axis_tready = 1'b0;
    mode = 0;
    mode_left = 0;
    forever begin
      @(posedge clk_i);
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(50, 400);
      end
      mode_left--;
      if (hold_cycles > 0) begin
        hold_cycles--;
        m_axis_tready <= 1'b0;
      end else begin
        case (mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= ($urandom_range(0, 1) == 1);
          2: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= ((mode_left % 8) < 5);
        endcase
      end
    end
  end

  function automatic logic [31:0] pick_coef();
    case ($urandom_range(0, 19))
      0, 1: return 32'd0;
      2: return 32'h8000_0000;
      3: return 32'h7fff_ffff;
      4: return 32'($urandom_range(0, 4)) - 32'd2;
      5, 6, 7, 8, 9: return $urandom;
      10, 11: return 32'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
      default: return 32'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
    endcase
  endfunction

  task automatic send_coefs(logic [31:0] a, logic [31:0] b, logic [31:0] c);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 16);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= IN_TDATA_W'({c, b, a});
    do @(posedge clk_i); while (!s_axis_tready);
    requests_sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    wait (pending == 0);
    repeat (Latency + 10) @(posedge clk_i);
  endtask

  task automatic write_option(logic v);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_phase(int n, int hold_at);
    for (int i = 0; i < n; i++) begin
      if (i == hold_at) hold_cycles = 500;
      send_coefs(pick_coef(), pick_coef(), pick_coef());
    end
  endtask

  task automatic directed_set();
    send_coefs(32'h0, 32'h0, 32'h0);
    send_coefs(32'h0, 32'h0, 32'h7fff_ffff);
    send_coefs(32'h0, 32'h0001_0000, 32'h0003_0000);
    send_coefs(32'h0, 32'h0000_0001, 32'h7fff_ffff);
    send_coefs(32'h0, 32'hffff_ffff, 32'h8000_0000);
    send_coefs(32'h0, 32'h8000_0000, 32'h8000_0000);
    send_coefs(32'h0001_0000, 32'hfffd_0000, 32'h0002_0000);
    send_coefs(32'h0001_0000, 32'h0, 32'h0001_0000);
    send_coefs(32'h0001_0000, 32'h0002_0000, 32'h0001_0000);
    send_coefs(32'h0000_0001, 32'h7fff_ffff, 32'h8000_0000);
    send_coefs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_coefs(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_coefs(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    send_coefs(32'h7fff_ffff, 32'h0, 32'h8000_0000);
    send_coefs(32'h0000_0001, 32'h0, 32'h7fff_ffff);
    send_coefs(32'hffff_ffff, 32'h0000_0001, 32'hffff_ffff);
    send_coefs(32'hfffe_0000, 32'h0001_0000, 32'hffff_0000);
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i = 1'b0;
    hold_cycles = 0;
    burst_left = 0;
    requests_sent = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed_set();
    drain();
    write_option(1'b0);
    directed_set();
    random_phase(500, 100);
    drain();
    write_option(1'b1);
    random_phase(700, 300);
    drain();
    write_option(1'b0);
    random_phase(300, -1);
    drain();
    write_option(1'b1);
    random_phase(400, 50);
    drain();

    $display("Sent %0d coefficient sets and checked %0d root results,", requests_sent,
             roots_seen);
    $display("with complex output toggled on and off and long output stalls.");
    if (fail_count == 0 && pending == 0) begin
      $display("tb_quadratic_root_solver passed");
    end else begin
      $display("tb_quadratic_root_solver failed");
    end
    $finish;
  end
endmodule

[quadratic_root_solver.f]
+incdir+rtl/core
rtl/core/qrs_pkg.sv
rtl/core/qrs_front.sv
rtl/core/qrs_queue.sv
rtl/core/qrs_back.sv
rtl/core/quadratic_root_solver.sv
sim/quadratic_root_solver_checker.sv
sim/tb_quadratic_root_solver.sv
